// ----- design/osmk_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the one-shot modifier key block.
// No dependencies; imported by every module of the block.
package osmk_pkg;

   localparam int unsigned MOD_COUNT = 5;

   localparam logic [2:0] CLASS_RSHIFT = 3'd0;
   localparam logic [2:0] CLASS_LSHIFT = 3'd1;
   localparam logic [2:0] CLASS_LALT   = 3'd2;
   localparam logic [2:0] CLASS_LCTRL  = 3'd3;
   localparam logic [2:0] CLASS_RGUI   = 3'd4;
   localparam logic [2:0] CLASS_OTHER  = 3'd5;

   localparam logic [15:0] TAP_WINDOW_RESET = 16'd500;

   typedef logic [MOD_COUNT-1:0] mod_mask_type;

   typedef struct packed {
      logic [2:0]  key_class;
      logic        pressed;
      logic [15:0] now_ms;
   } req_type;

   typedef struct packed {
      mod_mask_type held_mods;
      mod_mask_type armed_mods;
   } rsp_type;

endpackage

// ----- design/osmk_in_stage.sv -----
`timescale 1ns / 1ps
// Input register of the key event pipeline.
// Depends on osmk_pkg.
module osmk_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  osmk_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output osmk_pkg::req_type item
);
   import osmk_pkg::*;

   logic    item_valid_ff;
   logic    item_valid_in;
   req_type item_ff;
   logic    load;

   assign req_stall = item_valid_ff & ~advance;
   assign load      = ~req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (load) begin
         item_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (load && req_valid) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ----- design/osmk_core.sv -----
`timescale 1ns / 1ps
// Modifier state registers and the per-event update logic.
// Depends on osmk_pkg.
module osmk_core (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       tap_window,
   input  logic              fire,
   input  osmk_pkg::req_type item,
   output osmk_pkg::rsp_type rsp_next
);
   import osmk_pkg::*;

   mod_mask_type active_ff, active_in;
   mod_mask_type armed_ff, armed_in;
   mod_mask_type held_ff, held_in;
   logic [15:0]  press_time_ff, press_time_in;

   mod_mask_type bit_mask;
   mod_mask_type other_mask;
   mod_mask_type drop_mask;
   logic         is_mod;
   logic         other_on;
   logic         in_window;
   logic [15:0]  elapsed;

   always_comb begin
      is_mod     = (item.key_class < 3'(MOD_COUNT));
      bit_mask   = '0;
      other_mask = '0;
      if (is_mod) begin
         bit_mask[item.key_class] = 1'b1;
      end
      if (item.key_class == CLASS_RSHIFT) begin
         other_mask[CLASS_LSHIFT] = 1'b1;
      end else if (item.key_class == CLASS_LSHIFT) begin
         other_mask[CLASS_RSHIFT] = 1'b1;
      end
      elapsed   = item.now_ms - press_time_ff;
      in_window = (elapsed < tap_window);
      other_on  = |(active_ff & other_mask);
      drop_mask = bit_mask | (other_on ? other_mask : '0);

      active_in     = active_ff;
      armed_in      = armed_ff;
      held_in       = held_ff;
      press_time_in = press_time_ff;

      if (is_mod) begin
         if (item.pressed) begin
            if (~|(active_ff & bit_mask)) begin
               active_in     = active_ff | bit_mask;
               held_in       = held_ff | bit_mask;
               press_time_in = item.now_ms;
            end else begin
               active_in = active_ff & ~bit_mask;
               armed_in  = armed_ff & ~bit_mask;
            end
         end else begin
            if ((|(active_ff & bit_mask)) && !other_on && in_window) begin
               armed_in = armed_ff | bit_mask;
            end else begin
               active_in = active_ff & ~drop_mask;
               armed_in  = armed_ff & ~drop_mask;
               held_in   = held_ff & ~drop_mask;
            end
         end
      end else if (item.pressed) begin
         held_in   = held_ff & ~armed_ff;
         armed_in  = '0;
         active_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         armed_ff      <= '0;
         held_ff       <= '0;
         press_time_ff <= '0;
      end else if (fire) begin
         active_ff     <= active_in;
         armed_ff      <= armed_in;
         held_ff       <= held_in;
         press_time_ff <= press_time_in;
      end
   end

   assign rsp_next.held_mods  = held_in;
   assign rsp_next.armed_mods = armed_in;

endmodule

// ----- design/osmk_out_stage.sv -----
`timescale 1ns / 1ps
// Result register of the key event pipeline.
// Depends on osmk_pkg.
module osmk_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  osmk_pkg::rsp_type rsp_next,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output osmk_pkg::rsp_type rsp_data
);
   import osmk_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign advance = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid;
      end
      if (advance && item_valid) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/one_shot_modifier_keys.sv -----
`timescale 1ns / 1ps
// Top level of the one-shot modifier key block: tap window register and pipeline.
// Depends on osmk_pkg, osmk_in_stage, osmk_core, osmk_out_stage.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (osmk_pkg::req_type)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (osmk_pkg::rsp_type)
//   csr      in         csr_we                 csr_wdata (tap window, ms)
//
// One transaction per cycle unless the result is stalled; each result passes
// through the input register and the result register around the update.
// Reset clears modifier state and loads a 500 ms tap window.
// A stalled result holds the pipeline; the input register still takes one
// transaction while the result waits.
module one_shot_modifier_keys (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  osmk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output osmk_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import osmk_pkg::*;

   logic [15:0] tap_window_ff;
   logic        advance;
   logic        item_valid;
   req_type     item;
   rsp_type     rsp_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_window_ff <= TAP_WINDOW_RESET;
      end else if (csr_we) begin
         tap_window_ff <= csr_wdata;
      end
   end

   osmk_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   osmk_core u_core (
      .clock      (clock),
      .reset      (reset),
      .tap_window (tap_window_ff),
      .fire       (item_valid & advance),
      .item       (item),
      .rsp_next   (rsp_next)
   );

   osmk_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .rsp_next   (rsp_next),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- verif/one_shot_modifier_keys_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for one_shot_modifier_keys: directed and random key events.
// Depends on osmk_pkg and the one_shot_modifier_keys RTL; a scoreboard class predicts masks.
module one_shot_modifier_keys_tb;
   import osmk_pkg::*;

   localparam logic       KEY_DOWN       = 1'b1;
   localparam logic       KEY_UP         = 1'b0;
   localparam logic [2:0] CLASS_UNUSED_A = 3'd6;
   localparam logic [2:0] CLASS_UNUSED_B = 3'd7;
   localparam int         CYCLE_LIMIT    = 400000;
   localparam int         RANDOM_ITEMS   = 750;
   localparam int         PRESSURE_HOLD  = 80;

   class key_event_scoreboard;
      rsp_type      expected_masks[$];
      logic [15:0]  tap_window;
      logic [15:0]  press_stamp;
      mod_mask_type active_mods;
      mod_mask_type armed_mods;
      mod_mask_type held_mods;
      int           error_count;

      function new();
         tap_window  = TAP_WINDOW_RESET;
         press_stamp = '0;
         active_mods = '0;
         armed_mods  = '0;
         held_mods   = '0;
         error_count = 0;
      endfunction

      function void set_window(logic [15:0] w);
         tap_window = w;
      endfunction

      function int pending();
         return expected_masks.size();
      endfunction

      function rsp_type predict_masks(req_type ev);
         mod_mask_type key_bit;
         mod_mask_type twin_bit;
         mod_mask_type drop_bits;
         logic [15:0]  elapsed;
         logic         twin_on;
         rsp_type      r;
         if (ev.key_class < CLASS_OTHER) begin
            key_bit = mod_mask_type'(1) << ev.key_class;
            if (ev.pressed) begin
               if ((active_mods & key_bit) == '0) begin
                  active_mods |= key_bit;
                  held_mods   |= key_bit;
                  press_stamp  = ev.now_ms;
               end else begin
                  active_mods &= ~key_bit;
                  armed_mods  &= ~key_bit;
               end
            end else begin
               elapsed  = ev.now_ms - press_stamp;
               twin_bit = '0;
               if (ev.key_class == CLASS_RSHIFT)
                  twin_bit = mod_mask_type'(1) << CLASS_LSHIFT;
               else if (ev.key_class == CLASS_LSHIFT)
                  twin_bit = mod_mask_type'(1) << CLASS_RSHIFT;
               twin_on = (active_mods & twin_bit) != '0;
               if ((active_mods & key_bit) != '0 && !twin_on && elapsed < tap_window) begin
                  armed_mods |= key_bit;
               end else begin
                  drop_bits    = key_bit | (twin_on ? twin_bit : mod_mask_type'(0));
                  armed_mods  &= ~drop_bits;
                  active_mods &= ~drop_bits;
                  held_mods   &= ~drop_bits;
               end
            end
         end else if (ev.pressed) begin
            held_mods  &= ~armed_mods;
            armed_mods  = '0;
            active_mods = '0;
         end
         r.held_mods  = held_mods;
         r.armed_mods = armed_mods;
         return r;
      endfunction

      function void note_request(req_type ev);
         expected_masks.push_back(predict_masks(ev));
      endfunction

      task report(string msg);
         $display("%0t one_shot_modifier_keys_tb mismatch: %s", $time, msg);
         error_count++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_masks.size() == 0) begin
            report($sformatf("result %h with no pending transaction", got));
         end else begin
            want = expected_masks.pop_front();
            if (got.held_mods !== want.held_mods)
               report($sformatf("held_mods %b, want %b", got.held_mods, want.held_mods));
            if (got.armed_mods !== want.armed_mods)
               report($sformatf("armed_mods %b, want %b", got.armed_mods, want.armed_mods));
         end
      endtask

      task check_drained();
         if (expected_masks.size() != 0)
            report($sformatf("%0d results never arrived", expected_masks.size()));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [15:0] csr_wdata;

   key_event_scoreboard sb;
   logic [15:0] stamp_ms;
   bit          idle_on;
   int          hold_off_request;
   int          items_sent;
   int          cycle_count;

   one_shot_modifier_keys DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("one_shot_modifier_keys_tb: done, errors");
         $finish;
      end
   end

   function int pick_gap();
      if (!idle_on)
         return 0;
      return $urandom_range(0, 8);
   endfunction

   function logic [15:0] pick_advance();
      if ($urandom_range(0, 3) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 300));
   endfunction

   // Release delays, half of them on the tap window boundary.
   function logic [15:0] pick_delta();
      case ($urandom_range(0, 5))
         0:       return sb.tap_window - 16'd1;
         1:       return sb.tap_window;
         2:       return sb.tap_window + 16'd1;
         3:       return 16'($urandom_range(0, 50));
         4:       return 16'($urandom);
         default: return 16'($urandom_range(0, sb.tap_window));
      endcase
   endfunction

   task drive_event(logic [2:0] cls, logic prs, logic [15:0] t);
      req_type ev;
      int gap;
      ev.key_class = cls;
      ev.pressed   = prs;
      ev.now_ms    = t;
      stamp_ms     = t;
      gap          = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = ev;
      do @(posedge clock); while (req_stall);
      sb.note_request(ev);
      items_sent++;
   endtask

   task step_key(logic [2:0] cls, logic prs, logic [15:0] adv);
      drive_event(cls, prs, stamp_ms + adv);
   endtask

   task run_burst();
      logic [2:0] m;
      logic [2:0] m2;
      m  = 3'($urandom_range(0, 4));
      m2 = 3'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            step_key(m, KEY_DOWN, pick_advance());
            if ($urandom_range(0, 3) == 0)
               step_key(m2, KEY_DOWN, 16'($urandom_range(0, 100)));
            step_key(m, KEY_UP, pick_delta());
            if ($urandom_range(0, 1) == 0) begin
               step_key(CLASS_OTHER, KEY_DOWN, 16'($urandom_range(0, 100)));
               step_key(CLASS_OTHER, KEY_UP, 16'($urandom_range(0, 100)));
            end
         end
         4: begin
            step_key(CLASS_RSHIFT, KEY_DOWN, pick_advance());
            step_key(CLASS_LSHIFT, KEY_DOWN, 16'($urandom_range(0, 100)));
            step_key($urandom_range(0, 1) ? CLASS_RSHIFT : CLASS_LSHIFT, KEY_UP, pick_delta());
            step_key($urandom_range(0, 1) ? CLASS_RSHIFT : CLASS_LSHIFT, KEY_UP,
                     16'($urandom_range(0, 100)));
         end
         5: begin
            step_key(m, KEY_DOWN, pick_advance());
            step_key(m, KEY_DOWN, 16'($urandom_range(0, 100)));
            step_key(m, KEY_UP, pick_delta());
         end
         6: begin
            step_key(3'($urandom_range(5, 7)), KEY_DOWN, pick_advance());
            step_key(3'($urandom_range(5, 7)), KEY_UP, pick_advance());
         end
         7, 8: begin
            step_key(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 16'($urandom));
         end
         default: begin
            step_key(m, KEY_DOWN, pick_advance());
            step_key(m, KEY_UP, pick_delta());
            step_key(m2, KEY_DOWN, 16'($urandom_range(0, 100)));
            step_key(3'($urandom_range(5, 7)), KEY_DOWN, 16'($urandom_range(0, 100)));
            step_key(m2, KEY_UP, pick_delta());
         end
      endcase
   endtask

   task wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_tap_window(logic [15:0] w);
      wait_drained();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = w;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_window(w);
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int hold;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_request > 0) begin
            hold             = hold_off_request;
            hold_off_request = 0;
         end else begin
            hold = pick_gap();
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   end

   initial begin
      logic [15:0] windows [7];
      int per_phase;
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_stall        = 1'b0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      stamp_ms         = '0;
      idle_on          = 1'b1;
      hold_off_request = 0;
      items_sent       = 0;
      cycle_count      = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset window of 500 ms
      drive_event(CLASS_LSHIFT, KEY_DOWN, 16'd0);
      drive_event(CLASS_LSHIFT, KEY_UP, 16'd200);
      drive_event(CLASS_OTHER, KEY_DOWN, 16'd300);
      drive_event(CLASS_OTHER, KEY_UP, 16'd301);
      drive_event(CLASS_RGUI, KEY_DOWN, 16'd1000);
      drive_event(CLASS_RGUI, KEY_UP, 16'd1600);
      drive_event(CLASS_LCTRL, KEY_DOWN, 16'hFFFF);
      drive_event(CLASS_LCTRL, KEY_UP, 16'd100);
      drive_event(CLASS_LCTRL, KEY_DOWN, 16'd200);
      drive_event(CLASS_LCTRL, KEY_UP, 16'd210);
      drive_event(CLASS_RSHIFT, KEY_DOWN, 16'd300);
      drive_event(CLASS_LSHIFT, KEY_DOWN, 16'd310);
      drive_event(CLASS_RSHIFT, KEY_UP, 16'd320);
      drive_event(CLASS_LALT, KEY_DOWN, 16'd400);
      drive_event(CLASS_LALT, KEY_UP, 16'd899);
      drive_event(CLASS_UNUSED_A, KEY_DOWN, 16'd900);
      drive_event(CLASS_UNUSED_B, KEY_DOWN, 16'd901);
      drive_event(CLASS_RSHIFT, KEY_DOWN, 16'd1000);
      drive_event(CLASS_LSHIFT, KEY_UP, 16'd1010);
      drive_event(CLASS_LALT, KEY_DOWN, 16'd2000);
      drive_event(CLASS_LALT, KEY_UP, 16'd2500);
      drive_event(CLASS_LCTRL, KEY_DOWN, 16'd3000);
      drive_event(CLASS_OTHER, KEY_DOWN, 16'd3001);
      drive_event(CLASS_LCTRL, KEY_UP, 16'd3002);

      windows   = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'($urandom_range(2, 2000)),
                    TAP_WINDOW_RESET, 16'($urandom_range(2, 3000))};
      per_phase = RANDOM_ITEMS / 7;
      items_sent = 0;
      for (int p = 0; p < 7; p++) begin
         write_tap_window(windows[p]);
         idle_on = (p != 2);
         if (p == 1)
            hold_off_request = PRESSURE_HOLD;
         while (items_sent < per_phase * (p + 1))
            run_burst();
      end
      idle_on = 1'b1;

      wait_drained();
      repeat (16) @(posedge clock);
      sb.check_drained();
      if (sb.error_count == 0)
         $display("one_shot_modifier_keys_tb: done, clean");
      else
         $display("one_shot_modifier_keys_tb: done, errors");
      $finish;
   end

endmodule
